### src/emc_pkg.sv
// Types, constants and microcode ROM for the entropy mix conditioner.
package emc_pkg;

  typedef struct packed {
    logic [63:0] time_word_0;
    logic [63:0] time_word_1;
    logic [63:0] time_word_2;
    logic [7:0]  time_word_3;
    logic [63:0] monotonic_count;
    logic [63:0] timestamp_value;
    logic        health_test_pass;
    logic [63:0] random_sample_0;
    logic [63:0] random_sample_1;
    logic [63:0] random_sample_2;
    logic [2:0]  sample_valid_mask;
    logic [63:0] address_word;
  } in_word_t;

  typedef struct packed {
    logic [63:0] rand_lo;
    logic [63:0] rand_hi;
    logic [63:0] rand_64;
    logic [31:0] rand_32;
    logic [15:0] rand_16;
  } out_word_t;

  // working registers of the datapath
  typedef struct packed {
    logic [63:0] s0;
    logic [63:0] s1;
    logic [63:0] acc;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] v;
  } regs_t;

  typedef enum logic [3:0] {
    OP_XOR, OP_XORN, OP_ADD, OP_ADDH, OP_XSR, OP_ROLX, OP_ROLXN, OP_ZX32,
    OP_MUL, OP_CALL, OP_RET, OP_JMP, OP_CINC, OP_DONE
  } op_e;

  typedef enum logic [2:0] {
    R_S0, R_S1, R_ACC, R_A, R_B, R_T, R_U, R_V
  } reg_e;

  // first eight codes alias the working registers
  typedef enum logic [4:0] {
    S_S0, S_S1, S_ACC, S_A, S_B, S_T, S_U, S_V,
    S_TW0, S_TW1, S_TW2, S_TW3, S_MONO, S_TSC, S_RS0, S_RS1, S_RS2,
    S_ADDR, S_CNT, S_Z, S_K
  } src_e;

  typedef enum logic [3:0] {
    K_GOLD, K_MULA, K_MULB, K_MULC, K_ADDK, K_WYP0, K_WYP1, K_G32, K_M32
  } k_e;

  typedef enum logic [2:0] {
    C_NO_TSC, C_NO_RNG, C_NO_M0, C_NO_M1, C_NO_M2, C_MASK_NZ, C_NE
  } cond_e;

  typedef struct packed {
    op_e        op;
    reg_e       dst;
    src_e       sa;
    src_e       sb;
    logic [5:0] sh;
    k_e         k;
    cond_e      cnd;
    logic [7:0] tgt;
  } ucode_t;

  localparam logic [7:0] L_SPLIT = 8'd165;
  localparam logic [7:0] L_MUR   = 8'd172;
  localparam logic [7:0] L_XX    = 8'd178;
  localparam logic [7:0] L_WY    = 8'd191;

  function automatic logic [63:0] f_konst(k_e k);
    logic [63:0] r;
    unique case (k)
      K_GOLD:  r = 64'h9E3779B97F4A7C15;
      K_MULA:  r = 64'hBF58476D1CE4E5B9;
      K_MULB:  r = 64'h94D049BB133111EB;
      K_MULC:  r = 64'hC4CEB9FE1A85EC53;
      K_ADDK:  r = 64'h85EBCA77C2B2AE63;
      K_WYP0:  r = 64'hE7037ED1A0B428DB;
      K_WYP1:  r = 64'h8A96F1D043B03A13;
      K_G32:   r = 64'h000000009E3779B9;
      K_M32:   r = 64'h0000000085EBCA77;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic src_e rs(reg_e r);
    return src_e'({2'b00, r});
  endfunction

  function automatic ucode_t u_base(op_e op);
    ucode_t w;
    w.op  = op;
    w.dst = R_A;
    w.sa  = S_Z;
    w.sb  = S_Z;
    w.sh  = '0;
    w.k   = K_GOLD;
    w.cnd = C_NO_TSC;
    w.tgt = '0;
    return w;
  endfunction

  function automatic ucode_t u_alu(op_e op, reg_e d, src_e a, src_e b);
    ucode_t w;
    w     = u_base(op);
    w.dst = d;
    w.sa  = a;
    w.sb  = b;
    return w;
  endfunction

  function automatic ucode_t u_k(op_e op, reg_e d, src_e a, k_e k);
    ucode_t w;
    w     = u_alu(op, d, a, S_K);
    w.k   = k;
    return w;
  endfunction

  // d ^= d >> sh
  function automatic ucode_t u_xs(reg_e d, logic [5:0] sh);
    ucode_t w;
    w    = u_alu(OP_XSR, d, rs(d), S_Z);
    w.sh = sh;
    return w;
  endfunction

  // d ^= rotl(a or ~a, sh)
  function automatic ucode_t u_rl(op_e op, reg_e d, src_e a, logic [5:0] sh);
    ucode_t w;
    w    = u_alu(op, d, a, rs(d));
    w.sh = sh;
    return w;
  endfunction

  function automatic ucode_t u_call(logic [7:0] t);
    ucode_t w;
    w     = u_base(OP_CALL);
    w.tgt = t;
    return w;
  endfunction

  function automatic ucode_t u_jmp(cond_e c, logic [7:0] t);
    ucode_t w;
    w     = u_base(OP_JMP);
    w.cnd = c;
    w.tgt = t;
    return w;
  endfunction

  function automatic ucode_t u_mv(reg_e d, src_e a);
    return u_alu(OP_XOR, d, a, S_Z);
  endfunction

  // Program: args in A/B, subroutine result in A.
  function automatic ucode_t f_rom(logic [7:0] pc);
    ucode_t w;
    unique case (pc)
      8'd0:   w = u_alu(OP_XOR, R_S0, S_Z, S_Z);
      8'd1:   w = u_alu(OP_XOR, R_S1, S_Z, S_Z);
      8'd2:   w = u_alu(OP_XOR, R_ACC, S_Z, S_Z);
      // clock word 0
      8'd3:   w = u_alu(OP_XOR, R_A, S_ACC, S_TW0);
      8'd4:   w = u_call(L_SPLIT);
      8'd5:   w = u_mv(R_ACC, S_A);
      8'd6:   w = u_mv(R_A, S_TW0);
      8'd7:   w = u_mv(R_B, S_ACC);
      8'd8:   w = u_call(L_MUR);
      8'd9:   w = u_alu(OP_XOR, R_S0, S_S0, S_A);
      8'd10:  w = u_mv(R_A, S_S1);
      8'd11:  w = u_alu(OP_XOR, R_B, S_TW0, S_ACC);
      8'd12:  w = u_call(L_XX);
      8'd13:  w = u_mv(R_S1, S_A);
      // clock word 1
      8'd14:  w = u_alu(OP_XOR, R_A, S_ACC, S_TW1);
      8'd15:  w = u_call(L_SPLIT);
      8'd16:  w = u_mv(R_ACC, S_A);
      8'd17:  w = u_mv(R_A, S_TW1);
      8'd18:  w = u_mv(R_B, S_ACC);
      8'd19:  w = u_call(L_MUR);
      8'd20:  w = u_alu(OP_XOR, R_S0, S_S0, S_A);
      8'd21:  w = u_mv(R_A, S_S1);
      8'd22:  w = u_alu(OP_XOR, R_B, S_TW1, S_ACC);
      8'd23:  w = u_call(L_XX);
      8'd24:  w = u_mv(R_S1, S_A);
      // clock word 2
      8'd25:  w = u_alu(OP_XOR, R_A, S_ACC, S_TW2);
      8'd26:  w = u_call(L_SPLIT);
      8'd27:  w = u_mv(R_ACC, S_A);
      8'd28:  w = u_mv(R_A, S_TW2);
      8'd29:  w = u_mv(R_B, S_ACC);
      8'd30:  w = u_call(L_MUR);
      8'd31:  w = u_alu(OP_XOR, R_S0, S_S0, S_A);
      8'd32:  w = u_mv(R_A, S_S1);
      8'd33:  w = u_alu(OP_XOR, R_B, S_TW2, S_ACC);
      8'd34:  w = u_call(L_XX);
      8'd35:  w = u_mv(R_S1, S_A);
      // clock word 3
      8'd36:  w = u_alu(OP_XOR, R_A, S_ACC, S_TW3);
      8'd37:  w = u_call(L_SPLIT);
      8'd38:  w = u_mv(R_ACC, S_A);
      8'd39:  w = u_mv(R_A, S_TW3);
      8'd40:  w = u_mv(R_B, S_ACC);
      8'd41:  w = u_call(L_MUR);
      8'd42:  w = u_alu(OP_XOR, R_S0, S_S0, S_A);
      8'd43:  w = u_mv(R_A, S_S1);
      8'd44:  w = u_alu(OP_XOR, R_B, S_TW3, S_ACC);
      8'd45:  w = u_call(L_XX);
      8'd46:  w = u_mv(R_S1, S_A);
      // monotonic count
      8'd47:  w = u_alu(OP_XOR, R_A, S_S0, S_MONO);
      8'd48:  w = u_call(L_SPLIT);
      8'd49:  w = u_mv(R_S0, S_A);
      8'd50:  w = u_alu(OP_XOR, R_A, S_S1, S_MONO);
      8'd51:  w = u_call(L_SPLIT);
      8'd52:  w = u_mv(R_S1, S_A);
      8'd53:  w = u_mv(R_A, S_S0);
      8'd54:  w = u_mv(R_B, S_S1);
      8'd55:  w = u_call(L_WY);
      8'd56:  w = u_mv(R_U, S_A);
      8'd57:  w = u_mv(R_A, S_S0);
      8'd58:  w = u_mv(R_B, S_U);
      8'd59:  w = u_call(L_MUR);
      8'd60:  w = u_mv(R_S0, S_A);
      8'd61:  w = u_mv(R_A, S_S1);
      8'd62:  w = u_alu(OP_XORN, R_B, S_Z, S_U);
      8'd63:  w = u_call(L_MUR);
      8'd64:  w = u_mv(R_S1, S_A);
      // timestamp rotations
      8'd65:  w = u_jmp(C_NO_TSC, 8'd74);
      8'd66:  w = u_rl(OP_ROLX,  R_S0, S_TSC, 6'd1);
      8'd67:  w = u_rl(OP_ROLXN, R_S1, S_TSC, 6'd63);
      8'd68:  w = u_rl(OP_ROLX,  R_S0, S_TSC, 6'd21);
      8'd69:  w = u_rl(OP_ROLXN, R_S1, S_TSC, 6'd43);
      8'd70:  w = u_rl(OP_ROLX,  R_S0, S_TSC, 6'd41);
      8'd71:  w = u_rl(OP_ROLXN, R_S1, S_TSC, 6'd23);
      8'd72:  w = u_rl(OP_ROLX,  R_S0, S_TSC, 6'd61);
      8'd73:  w = u_rl(OP_ROLXN, R_S1, S_TSC, 6'd3);
      // hardware samples
      8'd74:  w = u_jmp(C_NO_RNG, 8'd98);
      8'd75:  w = u_jmp(C_NO_M0, 8'd80);
      8'd76:  w = u_mv(R_A, S_S0);
      8'd77:  w = u_mv(R_B, S_RS0);
      8'd78:  w = u_call(L_XX);
      8'd79:  w = u_mv(R_S0, S_A);
      8'd80:  w = u_jmp(C_NO_M1, 8'd85);
      8'd81:  w = u_mv(R_A, S_S1);
      8'd82:  w = u_mv(R_B, S_RS1);
      8'd83:  w = u_call(L_XX);
      8'd84:  w = u_mv(R_S1, S_A);
      8'd85:  w = u_jmp(C_NO_M2, 8'd91);
      8'd86:  w = u_mv(R_A, S_S0);
      8'd87:  w = u_mv(R_B, S_S1);
      8'd88:  w = u_call(L_WY);
      8'd89:  w = u_rl(OP_ROLX, R_S0, S_RS2, 6'd19);
      8'd90:  w = u_rl(OP_ROLX, R_S1, S_A, 6'd37);
      8'd91:  w = u_jmp(C_MASK_NZ, 8'd98);
      8'd92:  w = u_alu(OP_XOR, R_A, S_S0, S_S1);
      8'd93:  w = u_call(L_SPLIT);
      8'd94:  w = u_mv(R_S0, S_A);
      8'd95:  w = u_alu(OP_XOR, R_A, S_S1, S_S0);
      8'd96:  w = u_call(L_SPLIT);
      8'd97:  w = u_mv(R_S1, S_A);
      // address word
      8'd98:  w = u_mv(R_A, S_ADDR);
      8'd99:  w = u_mv(R_B, S_S1);
      8'd100: w = u_call(L_MUR);
      8'd101: w = u_alu(OP_XOR, R_S0, S_S0, S_A);
      8'd102: w = u_alu(OP_XORN, R_A, S_Z, S_ADDR);
      8'd103: w = u_mv(R_B, S_S0);
      8'd104: w = u_call(L_MUR);
      8'd105: w = u_alu(OP_XOR, R_S1, S_S1, S_A);
      8'd106: w = u_mv(R_A, S_S0);
      8'd107: w = u_mv(R_B, S_S1);
      8'd108: w = u_call(L_XX);
      8'd109: w = u_mv(R_S0, S_A);
      8'd110: w = u_mv(R_A, S_S1);
      8'd111: w = u_mv(R_B, S_S0);
      8'd112: w = u_call(L_XX);
      8'd113: w = u_mv(R_S1, S_A);
      8'd114: w = u_alu(OP_XOR, R_A, S_S0, S_S1);
      8'd115: w = u_call(L_SPLIT);
      8'd116: w = u_mv(R_U, S_A);
      8'd117: w = u_alu(OP_XOR, R_S0, S_S0, S_U);
      8'd118: w = u_mv(R_A, S_U);
      8'd119: w = u_call(L_SPLIT);
      8'd120: w = u_alu(OP_XOR, R_S1, S_S1, S_A);
      8'd121: w = u_mv(R_A, S_S0);
      8'd122: w = u_mv(R_B, S_S1);
      8'd123: w = u_call(L_WY);
      8'd124: w = u_mv(R_U, S_A);
      8'd125: w = u_mv(R_A, S_S1);
      8'd126: w = u_mv(R_B, S_S0);
      8'd127: w = u_call(L_WY);
      8'd128: w = u_mv(R_S1, S_A);
      8'd129: w = u_mv(R_S0, S_U);
      // equal halves fix
      8'd130: w = u_jmp(C_NE, 8'd137);
      8'd131: w = u_mv(R_A, S_S0);
      8'd132: w = u_call(L_SPLIT);
      8'd133: w = u_mv(R_S0, S_A);
      8'd134: w = u_mv(R_A, S_S1);
      8'd135: w = u_call(L_SPLIT);
      8'd136: w = u_mv(R_S1, S_A);
      // reseed fold
      8'd137: w = u_base(OP_CINC);
      8'd138: w = u_mv(R_A, S_CNT);
      8'd139: w = u_mv(R_B, S_S1);
      8'd140: w = u_call(L_MUR);
      8'd141: w = u_alu(OP_XOR, R_S0, S_S0, S_A);
      8'd142: w = u_alu(OP_XORN, R_A, S_Z, S_CNT);
      8'd143: w = u_mv(R_B, S_S0);
      8'd144: w = u_call(L_MUR);
      8'd145: w = u_alu(OP_XOR, R_S1, S_S1, S_A);
      8'd146: w = u_mv(R_A, S_S0);
      8'd147: w = u_call(L_SPLIT);
      8'd148: w = u_mv(R_S0, S_A);
      8'd149: w = u_mv(R_A, S_S1);
      8'd150: w = u_call(L_SPLIT);
      8'd151: w = u_mv(R_S1, S_A);
      // reductions
      8'd152: w = u_alu(OP_XOR, R_T, S_S0, S_S1);
      8'd153: w = u_k(OP_MUL, R_U, S_T, K_GOLD);
      8'd154: w = u_xs(R_U, 6'd32);
      8'd155: w = u_k(OP_MUL, R_U, S_U, K_MULC);
      8'd156: w = u_xs(R_U, 6'd32);
      8'd157: w = u_k(OP_MUL, R_V, S_T, K_G32);
      8'd158: w = u_alu(OP_ADDH, R_V, S_V, S_T);
      8'd159: w = u_alu(OP_ZX32, R_V, S_V, S_Z);
      8'd160: w = u_xs(R_V, 6'd16);
      8'd161: w = u_k(OP_MUL, R_V, S_V, K_M32);
      8'd162: w = u_alu(OP_ZX32, R_V, S_V, S_Z);
      8'd163: w = u_xs(R_V, 6'd13);
      8'd164: w = u_base(OP_DONE);
      // splitmix
      8'd165: w = u_k(OP_ADD, R_A, S_A, K_GOLD);
      8'd166: w = u_xs(R_A, 6'd30);
      8'd167: w = u_k(OP_MUL, R_A, S_A, K_MULA);
      8'd168: w = u_xs(R_A, 6'd27);
      8'd169: w = u_k(OP_MUL, R_A, S_A, K_MULB);
      8'd170: w = u_xs(R_A, 6'd31);
      8'd171: w = u_base(OP_RET);
      // murmur
      8'd172: w = u_alu(OP_XOR, R_A, S_A, S_B);
      8'd173: w = u_k(OP_MUL, R_A, S_A, K_GOLD);
      8'd174: w = u_xs(R_A, 6'd33);
      8'd175: w = u_k(OP_MUL, R_A, S_A, K_MULA);
      8'd176: w = u_xs(R_A, 6'd33);
      8'd177: w = u_base(OP_RET);
      // xxhash style
      8'd178: w = u_k(OP_MUL, R_B, S_B, K_MULA);
      8'd179: w = u_xs(R_B, 6'd33);
      8'd180: w = u_k(OP_MUL, R_B, S_B, K_MULB);
      8'd181: w = u_xs(R_B, 6'd29);
      8'd182: w = u_k(OP_MUL, R_B, S_B, K_MULC);
      8'd183: w = u_xs(R_B, 6'd32);
      8'd184: w = u_alu(OP_XOR, R_A, S_A, S_B);
      8'd185: w = u_k(OP_MUL, R_A, S_A, K_GOLD);
      8'd186: w = u_k(OP_ADD, R_A, S_A, K_ADDK);
      8'd187: w = u_xs(R_A, 6'd33);
      8'd188: w = u_k(OP_MUL, R_A, S_A, K_MULA);
      8'd189: w = u_xs(R_A, 6'd29);
      8'd190: w = u_base(OP_RET);
      // wyhash style
      8'd191: w = u_k(OP_XOR, R_A, S_A, K_WYP0);
      8'd192: w = u_k(OP_XOR, R_B, S_B, K_WYP1);
      8'd193: w = u_alu(OP_MUL, R_A, S_A, S_B);
      8'd194: w = u_xs(R_A, 6'd32);
      8'd195: w = u_k(OP_MUL, R_A, S_A, K_MULA);
      8'd196: w = u_xs(R_A, 6'd32);
      8'd197: w = u_base(OP_RET);
      default: w = u_base(OP_DONE);
    endcase
    return w;
  endfunction

endpackage

### src/entropy_mix_conditioner.sv
// Entropy mix conditioner: microcoded 64-bit mixer datapath and handshake.
//
// Usage:
//   Input word (in_valid_i/in_ready_o) carries the raw entropy fields of one
//   request; output word (out_valid_o/out_ready_i) carries the 128-bit
//   result and its 64/32/16-bit reductions. One output word per input word.
//   cfg_we_i/cfg_idx_i/cfg_data_i write tsc_enable (0) and rdrand_enable (1);
//   the user writes them only while the block is idle; it is not enforced.
//   Each 64-bit multiply is built from three products of the single shared
//   32x32 multiplier, taken in turn. With 80 to 96 multiplies per word,
//   that multiplier sets the rate.
//   One word is in work at a time; in_ready_o is high whenever the sequencer
//   is idle, also while a finished result waits in the output register, so
//   a new word can be taken in the cycle after the result is loaded.
//   If the receiver stalls, the sequencer holds at its final step until the
//   output register is free.
//   Reset clears the configuration, the reseed counter and all control
//   state; no output is valid after reset.
module entropy_mix_conditioner (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  emc_pkg::in_word_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output emc_pkg::out_word_t out_word_o
);
  import emc_pkg::*;

  logic        busy_q, busy_d;
  logic [7:0]  pc_q, pc_d;
  logic [7:0]  ret_q, ret_d;
  logic [1:0]  ph_q, ph_d;
  logic [63:0] cnt_q, cnt_d;
  logic        tsc_q, rdr_q;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_q, out_d;
  in_word_t    in_q;
  regs_t       rf_q, rf_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] prod_q, prod_d;

  ucode_t      uw;
  logic [63:0] kv, opa, opb, wr_val, pnext;
  logic [31:0] ma, mb;
  logic        wr_en, cond, accept;

  function automatic logic [63:0] pick(src_e s, regs_t r, in_word_t w,
                                       logic [63:0] c, logic [63:0] k);
    logic [63:0] v;
    unique case (s)
      S_S0:    v = r.s0;
      S_S1:    v = r.s1;
      S_ACC:   v = r.acc;
      S_A:     v = r.a;
      S_B:     v = r.b;
      S_T:     v = r.t;
      S_U:     v = r.u;
      S_V:     v = r.v;
      S_TW0:   v = w.time_word_0;
      S_TW1:   v = w.time_word_1;
      S_TW2:   v = w.time_word_2;
      S_TW3:   v = {56'd0, w.time_word_3};
      S_MONO:  v = w.monotonic_count;
      S_TSC:   v = w.timestamp_value;
      S_RS0:   v = w.random_sample_0;
      S_RS1:   v = w.random_sample_1;
      S_RS2:   v = w.random_sample_2;
      S_ADDR:  v = w.address_word;
      S_CNT:   v = c;
      S_K:     v = k;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rotl(logic [63:0] v, logic [5:0] r);
    return (v << r) | (v >> (7'd64 - {1'b0, r}));
  endfunction

  assign uw     = f_rom(pc_q);
  assign kv     = f_konst(uw.k);
  assign opa    = pick(uw.sa, rf_q, in_q, cnt_q, kv);
  assign opb    = pick(uw.sb, rf_q, in_q, cnt_q, kv);
  assign accept = in_valid_i && in_ready_o;

  assign in_ready_o  = !busy_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // 64x64 low product: lo*lo, then lo*hi and hi*lo shifted up
  assign ma     = (ph_q == 2'd2) ? opa[63:32] : opa[31:0];
  assign mb     = (ph_q == 2'd1) ? opb[63:32] : opb[31:0];
  assign pnext  = acc_q + {prod_q[31:0], 32'd0};

  always_comb begin
    unique case (uw.cnd)
      C_NO_TSC:  cond = !tsc_q;
      C_NO_RNG:  cond = !(rdr_q && in_q.health_test_pass);
      C_NO_M0:   cond = !in_q.sample_valid_mask[0];
      C_NO_M1:   cond = !in_q.sample_valid_mask[1];
      C_NO_M2:   cond = !in_q.sample_valid_mask[2];
      C_MASK_NZ: cond = (in_q.sample_valid_mask != 3'd0);
      C_NE:      cond = (rf_q.s0 != rf_q.s1);
      default:   cond = 1'b0;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    ret_d       = ret_q;
    ph_d        = ph_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    wr_en       = 1'b0;
    wr_val      = '0;

    if (busy_q) begin
      unique case (uw.op)
        OP_XOR:   begin wr_en = 1'b1; wr_val = opa ^ opb; end
        OP_XORN:  begin wr_en = 1'b1; wr_val = opa ^ ~opb; end
        OP_ADD:   begin wr_en = 1'b1; wr_val = opa + opb; end
        OP_ADDH:  begin wr_en = 1'b1; wr_val = opa + {32'd0, opb[63:32]}; end
        OP_XSR:   begin wr_en = 1'b1; wr_val = opa ^ (opa >> uw.sh); end
        OP_ROLX:  begin wr_en = 1'b1; wr_val = opb ^ rotl(opa, uw.sh); end
        OP_ROLXN: begin wr_en = 1'b1; wr_val = opb ^ rotl(~opa, uw.sh); end
        OP_ZX32:  begin wr_en = 1'b1; wr_val = {32'd0, opa[31:0]}; end
        OP_MUL: begin
          prod_d = 64'(ma * mb);
          ph_d   = ph_q + 2'd1;
          unique case (ph_q)
            2'd1:    acc_d = prod_q;
            2'd2:    acc_d = pnext;
            2'd3: begin
              wr_en  = 1'b1;
              wr_val = pnext;
            end
            default: acc_d = acc_q;
          endcase
        end
        OP_CALL: begin
          ret_d = pc_q + 8'd1;
          pc_d  = uw.tgt;
        end
        OP_RET:  pc_d = ret_q;
        OP_JMP:  pc_d = cond ? uw.tgt : pc_q + 8'd1;
        OP_CINC: cnt_d = cnt_q + 64'd1;
        OP_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_d.rand_lo = rf_q.s0;
            out_d.rand_hi = rf_q.s1;
            out_d.rand_64 = rf_q.u;
            out_d.rand_32 = rf_q.v[31:0];
            out_d.rand_16 = rf_q.v[31:16] ^ rf_q.v[15:0];
            out_valid_d   = 1'b1;
            busy_d        = 1'b0;
          end
        end
        default: ;
      endcase
      if (wr_en || uw.op == OP_CINC) begin
        pc_d = pc_q + 8'd1;
      end
    end else if (accept) begin
      busy_d = 1'b1;
      pc_d   = '0;
      ph_d   = '0;
    end
  end

  always_comb begin
    rf_d = rf_q;
    if (wr_en) begin
      unique case (uw.dst)
        R_S0:    rf_d.s0  = wr_val;
        R_S1:    rf_d.s1  = wr_val;
        R_ACC:   rf_d.acc = wr_val;
        R_A:     rf_d.a   = wr_val;
        R_B:     rf_d.b   = wr_val;
        R_T:     rf_d.t   = wr_val;
        R_U:     rf_d.u   = wr_val;
        R_V:     rf_d.v   = wr_val;
        default: rf_d     = rf_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      ret_q       <= '0;
      ph_q        <= '0;
      cnt_q       <= '0;
      tsc_q       <= 1'b0;
      rdr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      ret_q       <= ret_d;
      ph_q        <= ph_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i) begin
          rdr_q <= cfg_data_i;
        end else begin
          tsc_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rf_q   <= rf_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    out_q  <= out_d;
    if (accept) begin
      in_q <= in_word_i;
    end
  end

`ifndef SYNTHESIS
  a_mul_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != 2'd0) |-> (busy_q && uw.op == OP_MUL))
    else $error("multiply phase active outside a multiply step");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_q && pc_q == 8'd0 && ph_q == 2'd0))
    else $error("accepted word did not start the program");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= 8'd197))
    else $error("program counter left the ROM");

  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && uw.op == OP_CINC) |=> (cnt_q == $past(cnt_q) + 64'd1))
    else $error("reseed counter step wrong");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q && uw.op == OP_DONE))
    else $error("output valid without final step");
`endif

endmodule
